// ----- rtl/core/tch_pkg.sv -----
// shared constants, types and index helpers for the two-channel histogram
package tch_pkg;

  localparam int BLUE_BINS  = 256;
  localparam int GREEN_BINS = 256;
  localparam int COUNT_BITS = 32;

  function automatic int axis_log2(input int n);
    int k;
    int m;
    k = 0;
    m = (n > 256) ? 256 : n;
    for (int i = 0; i < 8; i++) begin
      if ((2 << k) <= m) begin
        k = k + 1;
      end
    end
    return k;
  endfunction

  localparam int BLOG   = axis_log2(BLUE_BINS);
  localparam int GLOG   = axis_log2(GREEN_BINS);
  localparam int ADDR_W = ((BLOG + GLOG) < 1) ? 1 : (BLOG + GLOG);
  localparam int DEPTH  = 1 << ADDR_W;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam logic [1:0] CMD_ACCUM = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic  busy;
    logic  wr_en;
    addr_t addr;
  } sweep_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    count_t wr_data;
  } ram_req_t;

  function automatic addr_t bin_index(input logic [7:0] row, input logic [7:0] col);
    logic [15:0] tmp;
    tmp = (16'(row) << GLOG) | 16'(col);
    return tmp[ADDR_W-1:0];
  endfunction

  function automatic addr_t accum_index(input logic [7:0] blue, input logic [7:0] green);
    logic [7:0] row;
    logic [7:0] col;
    row = blue >> (8 - BLOG);
    col = green >> (8 - GLOG);
    return bin_index(row, col);
  endfunction

  function automatic logic out_of_range(input logic [7:0] row, input logic [7:0] col);
    return ((row >> BLOG) != 8'd0) || ((col >> GLOG) != 8'd0);
  endfunction

  function automatic logic [31:0] clamp32(input count_t cnt);
    logic [63:0] w;
    w = 64'(cnt);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// ----- rtl/core/tch_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module tch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tch_sweep.sv -----
// clearing walk over the bin store, run after reset and on a clear command
module tch_sweep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output tch_pkg::sweep_t sweep
);
  import tch_pkg::*;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_CLEAR = 1'b1;

  logic  state_r, state_nxt;
  addr_t ptr_r, ptr_nxt;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    unique case (state_r)
      ST_RUN: begin
        if (start) begin
          state_nxt = ST_CLEAR;
          ptr_nxt   = '0;
        end
      end
      ST_CLEAR: begin
        ptr_nxt = ptr_r + addr_t'(1);
        if (ptr_r == '1) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  assign sweep.busy  = (state_r == ST_CLEAR);
  assign sweep.wr_en = (state_r == ST_CLEAR);
  assign sweep.addr  = ptr_r;

endmodule

// ----- rtl/core/tch_rmw.sv -----
// read-modify-write pipeline with write forwarding and the result register
module tch_rmw (
  input  logic              clk,
  input  logic              rst_n,
  input  tch_pkg::sweep_t   sweep,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_blue_value,
  input  logic [7:0]        in_green_value,
  input  logic [7:0]        in_query_row,
  input  logic [7:0]        in_query_col,
  output logic              clear_start,
  output tch_pkg::ram_req_t ram_req,
  input  tch_pkg::count_t   ram_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_bin_count
);
  import tch_pkg::*;

  logic        accept;
  logic        s1_v_r, s1_read_r, s1_zero_r;
  addr_t       s1_addr_r;
  logic        wq_v_r;
  addr_t       wq_addr_r;
  count_t      wq_data_r;
  count_t      fwd;
  count_t      inc;
  logic        acc_wr;
  logic        out_v_r, out_v_nxt;
  logic [31:0] out_data_r;

  assign in_ready = !sweep.busy && !(s1_v_r && s1_read_r) && (!out_v_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign clear_start = accept && (in_command == CMD_CLEAR);

  // a same-entry write still held in the write register is not yet visible at the ram output
  assign fwd    = (wq_v_r && (wq_addr_r == s1_addr_r)) ? wq_data_r : ram_rd_data;
  assign inc    = (fwd == COUNT_MAX) ? fwd : (fwd + count_t'(1));
  assign acc_wr = s1_v_r && !s1_read_r;

  always_comb begin
    ram_req.rd_en   = accept;
    ram_req.rd_addr = (in_command == CMD_READ) ? bin_index(in_query_row, in_query_col)
                                               : accum_index(in_blue_value, in_green_value);
    if (sweep.wr_en) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = sweep.addr;
      ram_req.wr_data = '0;
    end else begin
      ram_req.wr_en   = acc_wr;
      ram_req.wr_addr = s1_addr_r;
      ram_req.wr_data = inc;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_v_r && s1_read_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      wq_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= accept && ((in_command == CMD_ACCUM) || (in_command == CMD_READ));
      wq_v_r  <= ram_req.wr_en;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r <= (in_command == CMD_READ);
      s1_zero_r <= out_of_range(in_query_row, in_query_col);
      s1_addr_r <= ram_req.rd_addr;
    end
    wq_addr_r <= ram_req.wr_addr;
    wq_data_r <= ram_req.wr_data;
    if (s1_v_r && s1_read_r) begin
      out_data_r <= s1_zero_r ? 32'd0 : clamp32(fwd);
    end
  end

  assign out_valid     = out_v_r;
  assign out_bin_count = out_data_r;

endmodule

// ----- rtl/core/two_channel_histogram.sv -----
// top level of the two-channel (blue/green) pixel histogram
// Each accumulate transaction bins the blue and green bytes of a pixel and adds one,
// saturating, to that bin; accumulates are taken one per clock, back to back, through a
// read-modify-write on a single ram with one read and one write port, and an increment
// to the same bin in the next cycle is forwarded from the pending write. A read transaction
// returns its bin count (zero for a row or column outside the grid) via the stage-one and
// output registers; the input is held off while that result is in flight or waiting in
// the output register. After reset and every clear transaction, the 65536-entry store (by
// default) is zeroed by a walk of one entry per cycle, during which no transaction is accepted.
module two_channel_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_blue_value,
  input  logic [7:0]  in_green_value,
  input  logic [7:0]  in_query_row,
  input  logic [7:0]  in_query_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bin_count
);
  import tch_pkg::*;

  sweep_t   sweep;
  ram_req_t ram_req;
  count_t   ram_rd_data;
  logic     clear_start;

  tch_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (clear_start),
    .sweep (sweep)
  );

  tch_rmw u_rmw (
    .clk            (clk),
    .rst_n          (rst_n),
    .sweep          (sweep),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_blue_value  (in_blue_value),
    .in_green_value (in_green_value),
    .in_query_row   (in_query_row),
    .in_query_col   (in_query_col),
    .clear_start    (clear_start),
    .ram_req        (ram_req),
    .ram_rd_data    (ram_rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin_count  (out_bin_count)
  );

  tch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_bin_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
